@@ sv/prsd_pkg.sv @@
`default_nettype none

package prsd_pkg;

    localparam int MAX_NODES     = 64;
    localparam int WEIGHT_BITS   = 64;
    localparam int NODE_W        = 6;
    localparam int CNT_W         = 7;
    localparam int OCC_W         = $clog2(MAX_NODES);
    localparam int SEQ_DEPTH     = MAX_NODES - 2;
    localparam int IDX_W         = $clog2(SEQ_DEPTH);
    localparam int STEP_W        = $clog2(SEQ_DEPTH + 1);
    localparam int WIRE_WEIGHT_W = 64;
    localparam int IN_W          = 72;
    localparam int OUT_W         = 80;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(3);
    localparam logic [CNT_W-1:0] NODE_COUNT_MIN   = CNT_W'(3);
    localparam logic [CNT_W-1:0] NODE_COUNT_MAX   = CNT_W'(MAX_NODES);

    typedef logic [NODE_W-1:0]      node_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [OCC_W-1:0]       occ_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SEQ_RD,
        ST_OCC_RD,
        ST_STEP,
        ST_LAST_EMIT,
        ST_ERR_EMIT
    } prsd_state_t;

    typedef struct packed {
        logic  clear;
        logic  rd_en;
        node_t rd_addr;
        logic  wr_en;
        node_t wr_addr;
        occ_t  wr_data;
    } occ_cmd_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        node_t            wr_label;
        weight_t          wr_weight;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } item_cmd_t;

    typedef struct packed {
        node_t   leaf;
        node_t   joined;
        weight_t weight;
        logic    error;
        logic    last;
    } result_t;

    typedef struct packed {
        logic  scan_check;
        node_t scan_ptr;
    } status_t;

endpackage

`default_nettype wire

@@ sv/prsd_occ_store.sv @@
`default_nettype none

module prsd_occ_store
    import prsd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire occ_cmd_t cmd,
    output occ_t          occ
);

    occ_t                 occ_mem [MAX_NODES];
    logic [MAX_NODES-1:0] valid_reg;
    logic [MAX_NODES-1:0] valid_next;
    occ_t                 rd_data_reg;
    node_t                rd_addr_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = '0;
        end
        if (cmd.wr_en)
        begin
            valid_next[cmd.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            occ_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= occ_mem[cmd.rd_addr];
            rd_addr_reg <= cmd.rd_addr;
        end
    end

    // entries not counted in this run read as zero occurrences
    assign occ = valid_reg[rd_addr_reg] ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ sv/prsd_item_store.sv @@
`default_nettype none

module prsd_item_store
    import prsd_pkg::*;
(
    input  wire logic      clk,
    input  wire item_cmd_t cmd,
    output node_t          seq_rd,
    output weight_t        wgt_rd
);

    node_t   seq_mem [SEQ_DEPTH];
    weight_t wgt_mem [SEQ_DEPTH];
    node_t   seq_rd_reg;
    weight_t wgt_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            seq_mem[cmd.wr_addr] <= cmd.wr_label;
            wgt_mem[cmd.wr_addr] <= cmd.wr_weight;
        end
        if (cmd.rd_en)
        begin
            seq_rd_reg <= seq_mem[cmd.rd_addr];
            wgt_rd_reg <= wgt_mem[cmd.rd_addr];
        end
    end

    assign seq_rd = seq_rd_reg;
    assign wgt_rd = wgt_rd_reg;

endmodule

`default_nettype wire

@@ sv/prsd_out_reg.sv @@
`default_nettype none

module prsd_out_reg
    import prsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire result_t          result,
    output logic                  free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_W'({WIRE_WEIGHT_W'(result_reg.weight),
                              result_reg.joined, result_reg.leaf});
    assign m_tuser  = result_reg.error;
    assign m_tlast  = result_reg.last;

endmodule

`default_nettype wire

@@ sv/prsd_ctrl.sv @@
`default_nettype none

module prsd_ctrl
    import prsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] node_count,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire node_t            in_label,
    input  wire weight_t          in_weight,
    input  wire logic             in_final,
    output occ_cmd_t              occ_cmd,
    input  wire occ_t             occ_rd,
    output item_cmd_t             item_cmd,
    input  wire node_t            seq_rd,
    input  wire weight_t          wgt_rd,
    input  wire logic             out_free,
    output logic                  out_load,
    output result_t               out_result,
    output status_t               status
);

    prsd_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             err_reg, err_next;
    logic [STEP_W-1:0] step_reg, step_next;
    node_t            ptr_reg, ptr_next;
    node_t            leaf_reg, leaf_next;
    node_t            u_reg, u_next;
    node_t            label_reg, label_next;
    weight_t          last_w_reg, last_w_next;

    logic             count_ok;
    logic [CNT_W-1:0] seq_len;
    logic             store_ok;
    logic             run_bad;
    logic             u_leaf;
    logic             step_done;
    logic             accept;

    assign count_ok  = (node_count >= NODE_COUNT_MIN) && (node_count <= NODE_COUNT_MAX);
    assign seq_len   = node_count - CNT_W'(2);
    assign store_ok  = count_ok && (cnt_reg < seq_len);
    assign run_bad   = !count_ok || err_reg || (cnt_reg != seq_len);
    assign accept    = in_valid && in_ready;
    // the joined node becomes the next leaf when its occurrence count drops to zero below the scan point
    assign u_leaf    = (occ_rd == occ_t'(1)) && (u_reg < ptr_reg);
    assign step_done = (CNT_W'(step_reg) + CNT_W'(1)) == seq_len;

    assign in_ready = (state_reg == ST_IDLE);

    assign status.scan_check = (state_reg == ST_SCAN_CHK);
    assign status.scan_ptr   = ptr_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_final)
                    begin
                        state_next = run_bad ? ST_ERR_EMIT : ST_SCAN_RD;
                    end
                    else if (store_ok)
                    begin
                        state_next = ST_LOAD_WR;
                    end
                end
            end
            ST_LOAD_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (occ_rd == '0)
                begin
                    state_next = (CNT_W'(step_reg) == seq_len) ? ST_LAST_EMIT : ST_SEQ_RD;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SEQ_RD:
            begin
                state_next = ST_OCC_RD;
            end
            ST_OCC_RD:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (out_free)
                begin
                    if (u_leaf)
                    begin
                        state_next = step_done ? ST_LAST_EMIT : ST_SEQ_RD;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_LAST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and commands
    always_comb
    begin
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        step_next   = step_reg;
        ptr_next    = ptr_reg;
        leaf_next   = leaf_reg;
        u_next      = u_reg;
        label_next  = label_reg;
        last_w_next = last_w_reg;

        occ_cmd = '0;

        item_cmd           = '0;
        item_cmd.wr_addr   = cnt_reg[IDX_W-1:0];
        item_cmd.wr_label  = in_label;
        item_cmd.wr_weight = in_weight;
        item_cmd.rd_addr   = step_reg[IDX_W-1:0];

        out_load   = 1'b0;
        out_result = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!in_final)
                    begin
                        if (!store_ok)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (CNT_W'(in_label) >= node_count)
                            begin
                                err_next = 1'b1;
                            end
                            item_cmd.wr_en  = 1'b1;
                            occ_cmd.rd_en   = 1'b1;
                            occ_cmd.rd_addr = in_label;
                            occ_cmd.clear   = (cnt_reg == '0);
                            label_next      = in_label;
                            cnt_next        = cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        cnt_next    = '0;
                        err_next    = 1'b0;
                        ptr_next    = '0;
                        step_next   = '0;
                        last_w_next = in_weight;
                    end
                end
            end
            ST_LOAD_WR:
            begin
                occ_cmd.wr_en   = 1'b1;
                occ_cmd.wr_addr = label_reg;
                occ_cmd.wr_data = occ_rd + occ_t'(1);
            end
            ST_SCAN_RD:
            begin
                occ_cmd.rd_en   = 1'b1;
                occ_cmd.rd_addr = ptr_reg;
            end
            ST_SCAN_CHK:
            begin
                if (occ_rd == '0)
                begin
                    leaf_next = ptr_reg;
                end
                else
                begin
                    ptr_next = ptr_reg + node_t'(1);
                end
            end
            ST_SEQ_RD:
            begin
                item_cmd.rd_en = 1'b1;
            end
            ST_OCC_RD:
            begin
                occ_cmd.rd_en   = 1'b1;
                occ_cmd.rd_addr = seq_rd;
                u_next          = seq_rd;
            end
            ST_STEP:
            begin
                if (out_free)
                begin
                    out_load          = 1'b1;
                    out_result.leaf   = leaf_reg;
                    out_result.joined = u_reg;
                    out_result.weight = wgt_rd;
                    occ_cmd.wr_en     = (occ_rd != '0);
                    occ_cmd.wr_addr   = u_reg;
                    occ_cmd.wr_data   = occ_rd - occ_t'(1);
                    step_next         = step_reg + STEP_W'(1);
                    if (u_leaf)
                    begin
                        leaf_next = u_reg;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + node_t'(1);
                    end
                end
            end
            ST_LAST_EMIT:
            begin
                if (out_free)
                begin
                    // the highest label is never removed, so it is the other leaf
                    out_load          = 1'b1;
                    out_result.leaf   = leaf_reg;
                    out_result.joined = NODE_W'(node_count - CNT_W'(1));
                    out_result.weight = last_w_reg;
                    out_result.last   = 1'b1;
                end
            end
            ST_ERR_EMIT:
            begin
                if (out_free)
                begin
                    out_load         = 1'b1;
                    out_result.error = 1'b1;
                    out_result.last  = 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
            step_reg  <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            step_reg  <= step_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        leaf_reg   <= leaf_next;
        u_reg      <= u_next;
        label_reg  <= label_next;
        last_w_reg <= last_w_next;
    end

endmodule

`default_nettype wire

@@ sv/pruefer_sequence_decoder.sv @@
// Pruefer sequence to labeled tree decoder. Input stream: one transfer per
// sequence label, s_tdata = {pad, edge_weight, code_node}, s_tlast low; then
// one transfer with s_tlast high carrying only the last weight. node_count is
// set through cfg_wr_en/cfg_wr_data, by the user only while idle; the block
// does not enforce it. Output stream: node_count-1 edge transfers in order,
// m_tdata = {pad, out_weight, joined_node, leaf_node}, m_tlast on the last
// edge; or one transfer with m_tuser (error) and m_tlast high for a bad run.
// Load: each label is a read-modify-write of the occurrence count RAM.
// Decode: each sequence edge passes ST_SEQ_RD, ST_OCC_RD and ST_STEP, and
// each node the leaf scan pointer visits (it only moves up) passes ST_SCAN_RD
// and ST_SCAN_CHK; the last edge is emitted from ST_LAST_EMIT. The scan walks
// the single-port occurrence RAM one node at a time. s_tready is low during a
// label's write-back and the whole decode.
// Reset: node_count returns to 3, the run counter and error flag clear, the
// output register empties. The occurrence store is cleared on the first label
// of each run by its valid bits; no clearing pass is needed.
// A stalled m_tready holds the output register and the decode waits on it.
`default_nettype none

module pruefer_sequence_decoder
    import prsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // [5:0] code_node, [69:6] edge_weight
    input  wire logic             s_tlast,   // final_item
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // [5:0] leaf_node, [11:6] joined_node,
                                             // [75:12] out_weight
    output logic                  m_tuser,   // error
    output logic                  m_tlast,   // last_edge
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data // node_count
);

    logic [CNT_W-1:0] node_count_reg, node_count_next;
    occ_cmd_t         occ_cmd;
    occ_t             occ_rd;
    item_cmd_t        item_cmd;
    node_t            seq_rd;
    weight_t          wgt_rd;
    logic             out_free;
    logic             out_load;
    result_t          out_result;
    status_t          status;

    assign node_count_next = cfg_wr_en ? cfg_wr_data : node_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    prsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_count (node_count_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_label   (s_tdata[NODE_W-1:0]),
        .in_weight  (weight_t'(s_tdata[NODE_W +: WIRE_WEIGHT_W])),
        .in_final   (s_tlast),
        .occ_cmd    (occ_cmd),
        .occ_rd     (occ_rd),
        .item_cmd   (item_cmd),
        .seq_rd     (seq_rd),
        .wgt_rd     (wgt_rd),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_result (out_result),
        .status     (status)
    );

    prsd_occ_store u_occ_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (occ_cmd),
        .occ   (occ_rd)
    );

    prsd_item_store u_item_store (
        .clk    (clk),
        .cmd    (item_cmd),
        .seq_rd (seq_rd),
        .wgt_rd (wgt_rd)
    );

    prsd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .result   (out_result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a final transfer always starts result emission, so input must close
    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after final transfer");

    // the leaf scan never runs past the node range
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.scan_check |-> (CNT_W'(status.scan_ptr) < node_count_reg))
        else $error("leaf scan beyond node_count");

    // an error result is the only and last result, with an all-zero payload
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("malformed error result");

    // no result is produced while a label is being loaded
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> !out_load)
        else $error("result produced during load");

endmodule

`default_nettype wire

@@ tb/pruefer_sequence_checker.sv @@
`default_nettype none

module pruefer_sequence_checker
    import prsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // [5:0] code_node, [69:6] edge_weight
    input  wire logic             s_tlast,   // final_item
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata,   // [5:0] leaf_node, [11:6] joined_node,
                                             // [75:12] out_weight
    input  wire logic             m_tuser,   // error
    input  wire logic             m_tlast,   // last_edge
    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the block's state
    logic [CNT_W-1:0] node_cnt;
    node_t            seq_mem [SEQ_DEPTH];
    weight_t          wt_mem  [MAX_NODES-1];
    int               fill;
    logic             err_flag;

    // scratch for the tree decode
    int               deg  [MAX_NODES];
    bit               gone [MAX_NODES];

    result_t          edges_due [$];
    int               misses;

    function automatic bit count_legal();
        return node_cnt >= NODE_COUNT_MIN && node_cnt <= NODE_COUNT_MAX;
    endfunction

    function automatic void add_edge(node_t a, node_t b, weight_t w, logic e, logic l);
        result_t r;
        r.leaf   = a;
        r.joined = b;
        r.weight = w;
        r.error  = e;
        r.last   = l;
        edges_due.push_back(r);
    endfunction

    // smallest-labeled leaf still in the tree
    function automatic node_t take_leaf(int n);
        for (int v = 0; v < n; v++) begin
            if (!gone[v] && deg[v] == 1) begin
                gone[v] = 1'b1;
                return node_t'(v);
            end
        end
        return '0;
    endfunction

    function automatic void decode_tree(weight_t last_wgt);
        int    n;
        int    len;
        node_t u;
        node_t v;
        node_t a;
        node_t b;
        n   = int'(node_cnt);
        len = n - 2;
        wt_mem[len] = last_wgt;
        for (int i = 0; i < MAX_NODES; i++) begin
            deg[i]  = (i < n) ? 1 : 0;
            gone[i] = 1'b0;
        end
        for (int i = 0; i < len; i++)
            deg[seq_mem[i]]++;
        for (int i = 0; i < len; i++) begin
            u = seq_mem[i];
            v = take_leaf(n);
            if (deg[v] > 0)
                deg[v]--;
            if (deg[u] > 0)
                deg[u]--;
            add_edge(v, u, wt_mem[i], 1'b0, 1'b0);
        end
        a = take_leaf(n);
        b = take_leaf(n);
        add_edge(a, b, wt_mem[len], 1'b0, 1'b1);
    endfunction

    function automatic void absorb_item(node_t label, weight_t wgt, logic fin);
        if (!fin) begin
            if (!count_legal() || fill >= int'(node_cnt) - 2) begin
                err_flag = 1'b1;
                return;
            end
            if (int'(label) >= int'(node_cnt))
                err_flag = 1'b1;
            seq_mem[fill] = label;
            wt_mem[fill]  = wgt;
            fill++;
            return;
        end
        if (!count_legal() || err_flag || fill != int'(node_cnt) - 2)
            add_edge('0, '0, '0, 1'b1, 1'b1);
        else
            decode_tree(wgt);
        fill     = 0;
        err_flag = 1'b0;
    endfunction

    function automatic void check_field(string what, logic [WEIGHT_BITS-1:0] want,
                                        logic [WEIGHT_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            misses++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        result_t due;
        if (!rst_n) begin
            node_cnt   = NODE_COUNT_RESET;
            fill       = 0;
            err_flag   = 1'b0;
            misses     = 0;
            edges_due.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else begin
            if (cfg_wr_en)
                node_cnt = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                if (edges_due.size() == 0) begin
                    $display("%0t: edge expected none actual leaf %0d joined %0d error %b",
                             $time, m_tdata[0 +: NODE_W], m_tdata[NODE_W +: NODE_W], m_tuser);
                    misses++;
                end
                else begin
                    due = edges_due.pop_front();
                    check_field("leaf_node", due.leaf, m_tdata[0 +: NODE_W]);
                    check_field("joined_node", due.joined, m_tdata[NODE_W +: NODE_W]);
                    check_field("out_weight", due.weight, m_tdata[2*NODE_W +: WEIGHT_BITS]);
                    check_field("error", due.error, m_tuser);
                    check_field("last_edge", due.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                absorb_item(s_tdata[0 +: NODE_W], s_tdata[NODE_W +: WEIGHT_BITS], s_tlast);
            pending    <= edges_due.size();
            fail_count <= misses;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_pruefer_sequence_decoder.sv @@
`default_nettype none

module tb_pruefer_sequence_decoder;
    import prsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 110;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE       = 6 * MAX_NODES + 16;
    localparam int LIMIT_CYCLES = 300000;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata     = '0;
    logic             s_tlast     = 1'b0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    logic             m_tlast;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = NODE_COUNT_RESET;

    int               fail_count;
    int               pending;
    int               sent        = 0;
    int               cycles      = 0;
    int               stall_left  = 0;
    int               hold_left   = 0;
    logic             calm        = 1'b0;
    logic             hold_request = 1'b0;
    logic             hold_done   = 1'b0;

    int               base;
    int               n;
    int               runs;
    int               kind;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pruefer_sequence_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    pruefer_sequence_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic weight_t any_weight();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one long hold-off of the output on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_request && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // output side: random stalls, and none taken while the hold-off runs
    always @(posedge clk)
    begin
        if (hold_left > 0)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (calm || $urandom_range(0, 99) < 75)
            m_tready <= 1'b1;
        else
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    task automatic send_item(input node_t label, input weight_t wgt, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - NODE_W - WEIGHT_BITS){1'b0}}, wgt, label};
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // wait until every edge is out and the block has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_phase(input int count);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(count);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_valid_run(input int count);
        for (int i = 0; i < count - 2; i++)
            send_item(node_t'($urandom_range(0, count - 1)), any_weight(), 1'b0);
        send_item(node_t'($urandom), any_weight(), 1'b1);
    endtask

    // one label at or above the node count
    task automatic send_bad_label_run(input int count);
        int pos;
        pos = $urandom_range(0, count - 3);
        for (int i = 0; i < count - 2; i++)
            if (i == pos)
                send_item(node_t'($urandom_range(count, MAX_NODES - 1)), any_weight(), 1'b0);
            else
                send_item(node_t'($urandom_range(0, count - 1)), any_weight(), 1'b0);
        send_item(node_t'($urandom), any_weight(), 1'b1);
    endtask

    task automatic send_long_run(input int count);
        int extra;
        extra = $urandom_range(1, 3);
        for (int i = 0; i < count - 2 + extra; i++)
            send_item(node_t'($urandom_range(0, count - 1)), any_weight(), 1'b0);
        send_item(node_t'($urandom), any_weight(), 1'b1);
    endtask

    task automatic send_short_run(input int count);
        int k;
        k = $urandom_range(0, count - 3);
        for (int i = 0; i < k; i++)
            send_item(node_t'($urandom_range(0, count - 1)), any_weight(), 1'b0);
        send_item(node_t'($urandom), any_weight(), 1'b1);
    endtask

    // any labels at all, for a node count the block cannot decode
    task automatic send_stray_run();
        int k;
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++)
            send_item(node_t'($urandom), any_weight(), 1'b0);
        send_item(node_t'($urandom), any_weight(), 1'b1);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest tree, weight extremes, ignored final label
        set_phase(NODE_COUNT_RESET);
        send_item(node_t'(0), weight_t'(0), 1'b0);
        send_item(node_t'(0), '1, 1'b1);
        send_item(node_t'(2), weight_t'(64'h5555_5555_5555_5555), 1'b0);
        send_item(node_t'(63), weight_t'(64'hAAAA_AAAA_AAAA_AAAA), 1'b1);
        // label out of range, just above and at the top of the field
        send_item(node_t'(3), '1, 1'b0);
        send_item(node_t'(0), weight_t'(0), 1'b1);
        send_item(node_t'(63), weight_t'(64'h0123_4567_89AB_CDEF), 1'b0);
        send_item(node_t'(1), weight_t'(64'hFEDC_BA98_7654_3210), 1'b1);
        // one label too many, then a final with no labels at all
        send_item(node_t'(1), weight_t'(1), 1'b0);
        send_item(node_t'(1), weight_t'(2), 1'b0);
        send_item(node_t'(0), weight_t'(3), 1'b1);
        send_item(node_t'(0), '1, 1'b1);
        // star around the top node
        set_phase(4);
        send_item(node_t'(3), '1, 1'b0);
        send_item(node_t'(3), weight_t'(0), 1'b0);
        send_item(node_t'(0), weight_t'(64'h8000_0000_0000_0001), 1'b1);
        // node counts the block cannot decode
        set_phase(2);
        send_item(node_t'(0), weight_t'(5), 1'b0);
        send_item(node_t'(0), weight_t'(6), 1'b1);
        set_phase(127);
        send_item(node_t'(0), '1, 1'b1);
        set_phase(0);
        send_item(node_t'(5), weight_t'(7), 1'b0);
        send_item(node_t'(0), weight_t'(8), 1'b1);

        // largest tree with the output held off; the next run backs up behind it
        base = sent;
        set_phase(MAX_NODES);
        send_valid_run(MAX_NODES);
        hold_request <= 1'b1;
        send_short_run(MAX_NODES);

        while (sent - base < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
                n = $urandom_range(3, 8);
            else if (kind < 85)
                n = $urandom_range(9, 24);
            else if (kind < 92)
                n = $urandom_range(25, MAX_NODES);
            else if (kind < 96)
                n = $urandom_range(0, 2);
            else
                n = $urandom_range(MAX_NODES + 1, 127);
            calm <= ($urandom_range(0, 4) == 0);
            set_phase(n);
            runs = $urandom_range(1, 4);
            for (int r = 0; r < runs; r++)
            begin
                kind = $urandom_range(0, 99);
                if (n < 3 || n > MAX_NODES)
                    send_stray_run();
                else if (kind < 82)
                    send_valid_run(n);
                else if (kind < 88 && n < MAX_NODES)
                    send_bad_label_run(n);
                else if (kind < 94)
                    send_long_run(n);
                else
                    send_short_run(n);
            end
        end

        drain();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
